FILE: rtl/msrc_pkg.sv
// msrc_pkg: shared types, codes and constants of the setpoint ramp commander
// no dependencies; imported by the interfaces and every module of the block
package msrc_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // command codes
  localparam logic [ACTION_W-1:0] ACT_TICK         = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START        = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP         = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SETPOINT     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SETPOINT_ALL = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_STATUS       = 3'd5;

  // status codes carried in feedback words
  localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STOPPED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd3;

  // register indexes
  localparam logic [1:0] REG_MAX_SETPOINT    = 2'd0;
  localparam logic [1:0] REG_RAMP_STEP       = 2'd1;
  localparam logic [1:0] REG_STOP_STEP       = 2'd2;
  localparam logic [1:0] REG_STOP_HOLD_TICKS = 2'd3;

  // register reset values
  localparam logic [VAL_W-1:0] RST_MAX_SETPOINT    = 16'd6200;
  localparam logic [VAL_W-1:0] RST_RAMP_STEP       = 16'd5;
  localparam logic [VAL_W-1:0] RST_STOP_STEP       = 16'd1;
  localparam logic [VAL_W-1:0] RST_STOP_HOLD_TICKS = 16'd1000;

  localparam logic [VAL_W-1:0] STOP_COUNT_LOAD = 16'hFFFF;
  localparam logic [LEN_W-1:0] MIN_LEN_SETPOINT     = 4'd2;
  localparam logic [LEN_W-1:0] MIN_LEN_SETPOINT_ALL = 4'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LEN_W-1:0]    payload_length;
    logic [VAL_W-1:0]    setpoint_value;
    logic [VAL_W-1:0]    rpm_sample;
  } item_t;

  typedef struct packed {
    logic                feedback_valid;
    logic [STATUS_W-1:0] feedback_status;
    logic [VAL_W-1:0]    feedback_rpm;
    logic [VAL_W-1:0]    ramped_setpoint;
    logic                drive_zero;
    logic                pid_reset;
    logic                led_on;
  } result_t;

  typedef struct packed {
    logic [VAL_W-1:0] max_setpoint;
    logic [VAL_W-1:0] ramp_step;
    logic [VAL_W-1:0] stop_step;
    logic [VAL_W-1:0] stop_hold_ticks;
    logic [VAL_W-1:0] stop_hold_rem;   // stop_hold_ticks modulo feedback period
  } cfg_t;

endpackage

FILE: rtl/msrc_cmd_if.sv
// msrc_cmd_if: valid/ready channel carrying one command or tick word
// depends on msrc_pkg for field widths
interface msrc_cmd_if;
  import msrc_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [LEN_W-1:0]    payload_length;
  logic [VAL_W-1:0]    setpoint_value;
  logic [VAL_W-1:0]    rpm_sample;

  modport source (output valid, output action, output payload_length,
                  output setpoint_value, output rpm_sample, input ready);
  modport sink   (input valid, input action, input payload_length,
                  input setpoint_value, input rpm_sample, output ready);
endinterface

FILE: rtl/msrc_rsp_if.sv
// msrc_rsp_if: valid/ready channel carrying one result word
// depends on msrc_pkg for field widths
interface msrc_rsp_if;
  import msrc_pkg::*;

  logic                valid;
  logic                ready;
  logic                feedback_valid;
  logic [STATUS_W-1:0] feedback_status;
  logic [VAL_W-1:0]    feedback_rpm;
  logic [VAL_W-1:0]    ramped_setpoint;
  logic                drive_zero;
  logic                pid_reset;
  logic                led_on;

  modport source (output valid, output feedback_valid, output feedback_status,
                  output feedback_rpm, output ramped_setpoint, output drive_zero,
                  output pid_reset, output led_on, input ready);
  modport sink   (input valid, input feedback_valid, input feedback_status,
                  input feedback_rpm, input ramped_setpoint, input drive_zero,
                  input pid_reset, input led_on, output ready);
endinterface

FILE: rtl/msrc_cfg_regs.sv
// msrc_cfg_regs: apb register file plus a two-stage reciprocal pipeline that
// keeps stop_hold_ticks modulo the feedback period; depends on msrc_pkg
module msrc_cfg_regs #(
  parameter int unsigned FEEDBACK_PERIOD = 100
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [msrc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [msrc_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [msrc_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output msrc_pkg::cfg_t                       cfg
);
  import msrc_pkg::*;

  // q = (x * RecipK) >> RecipShift is exact for every 16-bit x
  localparam int unsigned RecipShift = VAL_W + $clog2(FEEDBACK_PERIOD);
  localparam logic [63:0] RecipWide  =
    ((64'd1 << RecipShift) + 64'(FEEDBACK_PERIOD) - 64'd1) / 64'(FEEDBACK_PERIOD);
  localparam logic [VAL_W:0] RecipK  = RecipWide[VAL_W:0];
  localparam logic [VAL_W-1:0] HoldQuoRst = 16'(32'(RST_STOP_HOLD_TICKS) / FEEDBACK_PERIOD);
  localparam logic [VAL_W-1:0] HoldRemRst = 16'(32'(RST_STOP_HOLD_TICKS) % FEEDBACK_PERIOD);
  localparam logic [VAL_W-1:0] PeriodVal  = 16'(FEEDBACK_PERIOD);

  logic [VAL_W-1:0] max_setpoint_r, ramp_step_r, stop_step_r, stop_hold_r;
  logic [VAL_W-1:0] hold_d_r, hold_quo_r, hold_rem_r;
  logic [VAL_W-1:0] hold_quo_nxt, hold_rem_nxt;
  logic [2*VAL_W:0]   quo_prod;
  logic [2*VAL_W-1:0] back_prod;
  logic             wr_en;
  logic             hold_setup, hold_wr;

  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite;
  assign hold_setup = psel && !penable && pwrite && (paddr[3:2] == REG_STOP_HOLD_TICKS);
  assign hold_wr    = wr_en && (paddr[3:2] == REG_STOP_HOLD_TICKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_setpoint_r <= RST_MAX_SETPOINT;
      ramp_step_r    <= RST_RAMP_STEP;
      stop_step_r    <= RST_STOP_STEP;
      stop_hold_r    <= RST_STOP_HOLD_TICKS;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MAX_SETPOINT:    max_setpoint_r <= pwdata[VAL_W-1:0];
        REG_RAMP_STEP:       ramp_step_r    <= pwdata[VAL_W-1:0];
        REG_STOP_STEP:       stop_step_r    <= pwdata[VAL_W-1:0];
        REG_STOP_HOLD_TICKS: stop_hold_r    <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_SETPOINT:    prdata = {16'd0, max_setpoint_r};
      REG_RAMP_STEP:       prdata = {16'd0, ramp_step_r};
      REG_STOP_STEP:       prdata = {16'd0, stop_step_r};
      REG_STOP_HOLD_TICKS: prdata = {16'd0, stop_hold_r};
      default:             prdata = '0;
    endcase
  end

  // setup cycle: quotient of the incoming value by reciprocal
  // access cycle: remainder, stored at the same edge as the register
  assign quo_prod     = {17'd0, pwdata[VAL_W-1:0]} * {16'd0, RecipK};
  assign hold_quo_nxt = 16'(quo_prod >> RecipShift);
  assign back_prod    = {16'd0, hold_quo_r} * {16'd0, PeriodVal};
  assign hold_rem_nxt = 16'(32'(hold_d_r) - back_prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_d_r   <= RST_STOP_HOLD_TICKS;
      hold_quo_r <= HoldQuoRst;
      hold_rem_r <= HoldRemRst;
    end else begin
      if (hold_setup) begin
        hold_d_r   <= pwdata[VAL_W-1:0];
        hold_quo_r <= hold_quo_nxt;
      end
      if (hold_wr) begin
        hold_rem_r <= hold_rem_nxt;
      end
    end
  end

  assign cfg.max_setpoint    = max_setpoint_r;
  assign cfg.ramp_step       = ramp_step_r;
  assign cfg.stop_step       = stop_step_r;
  assign cfg.stop_hold_ticks = stop_hold_r;
  assign cfg.stop_hold_rem   = hold_rem_r;

endmodule

FILE: rtl/msrc_engine.sv
// msrc_engine: command state registers and the single-pass next-state and
// result logic for one word; depends on msrc_pkg
module msrc_engine #(
  parameter int unsigned FEEDBACK_PERIOD = 100,
  parameter int unsigned SETPOINT_WIDTH  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  msrc_pkg::item_t   item,
  input  msrc_pkg::cfg_t    cfg,
  output msrc_pkg::result_t result
);
  import msrc_pkg::*;

  localparam logic [VAL_W-1:0] SpMask =
    (SETPOINT_WIDTH >= VAL_W) ? 16'hFFFF : 16'((32'd1 << SETPOINT_WIDTH) - 32'd1);
  localparam logic [VAL_W-1:0] PeriodLast = 16'(FEEDBACK_PERIOD - 1);
  localparam logic [VAL_W-1:0] StopLoadRem = 16'(32'(STOP_COUNT_LOAD) % FEEDBACK_PERIOD);

  logic                running_r, running_nxt;
  logic                stop_r, stop_nxt;
  logic                lamp_r, lamp_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [VAL_W-1:0]    target_r, target_nxt;
  logic [VAL_W-1:0]    ramp_r, ramp_nxt;
  logic [VAL_W-1:0]    rpm_r, rpm_nxt;
  logic [VAL_W-1:0]    cd_r, cd_nxt;
  logic [VAL_W-1:0]    cd_mod_r, cd_mod_nxt;   // countdown modulo feedback period

  logic [VAL_W-1:0] mod_dec, diff_up, diff_dn, clamped;
  logic             send;

  assign mod_dec = (cd_mod_r == '0) ? PeriodLast : cd_mod_r - 16'd1;
  assign diff_up = target_r - ramp_r;
  assign diff_dn = ramp_r - target_r;
  assign clamped = ((item.setpoint_value > cfg.max_setpoint) ?
                    cfg.max_setpoint : item.setpoint_value) & SpMask;

  always_comb begin
    running_nxt = running_r;
    stop_nxt    = stop_r;
    lamp_nxt    = lamp_r;
    status_nxt  = status_r;
    target_nxt  = target_r;
    ramp_nxt    = ramp_r;
    rpm_nxt     = rpm_r;
    cd_nxt      = cd_r;
    cd_mod_nxt  = cd_mod_r;
    send        = 1'b0;
    result      = '0;

    if (item.action == ACT_TICK) begin
      if (cd_r != '0) begin
        cd_nxt     = cd_r - 16'd1;
        cd_mod_nxt = mod_dec;
        if (mod_dec == '0) begin
          result.feedback_valid  = 1'b1;
          result.feedback_status = status_r;
          result.feedback_rpm    = rpm_r;
        end
      end
      rpm_nxt = item.rpm_sample;
      if (!running_r) begin
        result.drive_zero = 1'b1;
        lamp_nxt          = 1'b0;
      end else begin
        if (stop_r) begin
          if (ramp_r > cfg.stop_step) begin
            ramp_nxt = ramp_r - cfg.stop_step;
          end else begin
            ramp_nxt   = '0;
            stop_nxt   = 1'b0;
            cd_nxt     = cfg.stop_hold_ticks;
            cd_mod_nxt = cfg.stop_hold_rem;
          end
        end else if (ramp_r < target_r) begin
          ramp_nxt = (diff_up > cfg.ramp_step) ? (ramp_r + cfg.ramp_step) & SpMask : target_r;
        end else if (ramp_r > target_r) begin
          ramp_nxt = (diff_dn > cfg.ramp_step) ? ramp_r - cfg.ramp_step : target_r;
        end
        if (ramp_nxt == '0) begin
          result.drive_zero = 1'b1;
          result.pid_reset  = 1'b1;
        end
      end
    end else begin
      send = 1'b1;
      case (item.action) inside
        ACT_START: begin
          running_nxt = 1'b1;
          status_nxt  = ST_RUNNING;
          lamp_nxt    = 1'b1;
        end
        ACT_STOP: begin
          stop_nxt   = 1'b1;
          target_nxt = '0;
          cd_nxt     = STOP_COUNT_LOAD;
          cd_mod_nxt = StopLoadRem;
          status_nxt = ST_STOPPED;
          lamp_nxt   = 1'b0;
        end
        ACT_SETPOINT, ACT_SETPOINT_ALL: begin
          if ((item.action == ACT_SETPOINT && item.payload_length < MIN_LEN_SETPOINT) ||
              (item.action == ACT_SETPOINT_ALL &&
               item.payload_length < MIN_LEN_SETPOINT_ALL)) begin
            send = 1'b0;
          end else begin
            target_nxt = clamped;
            if (!running_r) begin
              status_nxt = ST_STOPPED;
            end else begin
              stop_nxt   = 1'b0;
              cd_nxt     = '0;
              cd_mod_nxt = '0;
              status_nxt = ST_RUNNING;
            end
          end
        end
        ACT_STATUS: ;
        default: status_nxt = ST_ERROR;
      endcase
      if (send) begin
        result.feedback_valid  = 1'b1;
        result.feedback_status = status_nxt;
        result.feedback_rpm    = rpm_r;
      end
    end

    result.ramped_setpoint = ramp_nxt;
    result.led_on          = lamp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      stop_r    <= 1'b0;
      lamp_r    <= 1'b0;
      status_r  <= ST_STOPPED;
      target_r  <= '0;
      ramp_r    <= '0;
      rpm_r     <= '0;
      cd_r      <= '0;
      cd_mod_r  <= '0;
    end else if (advance) begin
      running_r <= running_nxt;
      stop_r    <= stop_nxt;
      lamp_r    <= lamp_nxt;
      status_r  <= status_nxt;
      target_r  <= target_nxt;
      ramp_r    <= ramp_nxt;
      rpm_r     <= rpm_nxt;
      cd_r      <= cd_nxt;
      cd_mod_r  <= cd_mod_nxt;
    end
  end

endmodule

FILE: rtl/motor_setpoint_ramp_commander_top.sv
// motor_setpoint_ramp_commander_top: input register, engine, result register
// depends on msrc_pkg, msrc_cmd_if, msrc_rsp_if, msrc_cfg_regs, msrc_engine
//
// usage
// - in_chan takes one word per command or 1 ms tick (action, payload length,
//   setpoint value, measured rpm); out_chan gives exactly one result word per
//   input word, in order: optional feedback frame, ramped setpoint, drive-zero,
//   pid-reset and led state
// - the cfg_ apb port holds max_setpoint, ramp_step, stop_step and
//   stop_hold_ticks at byte addresses 0, 4, 8 and 12; pready is tied high
// - throughput is one word per cycle while out_chan is not stalled; a word's
//   result is worked out by the single compute pass between the input and
//   result registers and shown on out_chan from the result register
// - a stop_hold_ticks write has its quotient worked out in the apb setup cycle
//   and its feedback-period remainder stored at the same edge as the write
// - reset (rst_n low, synchronous) restores the register defaults and the
//   stopped, not-running state and drops any word held in either register
// - when the receiver stalls the result word is held; one more word is taken
//   into the input register, after which in_chan.ready stays low
module motor_setpoint_ramp_commander_top #(
  parameter int unsigned FEEDBACK_PERIOD = 100,
  parameter int unsigned SETPOINT_WIDTH  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  msrc_cmd_if.sink                          in_chan,
  msrc_rsp_if.source                        out_chan,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [msrc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [msrc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [msrc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import msrc_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  result_t res_comb, res_r;
  logic    item_valid_r, item_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    advance;     // word in the input register moves to the result
  logic    in_take;

  msrc_cfg_regs #(
    .FEEDBACK_PERIOD (FEEDBACK_PERIOD)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  msrc_engine #(
    .FEEDBACK_PERIOD (FEEDBACK_PERIOD),
    .SETPOINT_WIDTH  (SETPOINT_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (res_comb)
  );

  // handshake: the result register frees itself when taken, so the input
  // register can refill in the same cycle
  assign advance        = item_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !item_valid_r || advance;
  assign in_take        = in_chan.valid && in_chan.ready;
  assign item_valid_nxt = in_take || (item_valid_r && !advance);
  assign out_valid_nxt  = advance || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action         <= in_chan.action;
      item_r.payload_length <= in_chan.payload_length;
      item_r.setpoint_value <= in_chan.setpoint_value;
      item_r.rpm_sample     <= in_chan.rpm_sample;
    end
    if (advance) begin
      res_r <= res_comb;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.feedback_valid  = res_r.feedback_valid;
  assign out_chan.feedback_status = res_r.feedback_status;
  assign out_chan.feedback_rpm    = res_r.feedback_rpm;
  assign out_chan.ramped_setpoint = res_r.ramped_setpoint;
  assign out_chan.drive_zero      = res_r.drive_zero;
  assign out_chan.pid_reset       = res_r.pid_reset;
  assign out_chan.led_on          = res_r.led_on;

  // pid reset only ever comes with the drive forced to zero
  a_pid_implies_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.pid_reset |-> res_r.drive_zero)
    else $error("pid_reset without drive_zero");

  // no frame means empty frame fields
  a_frame_fields_clear : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.feedback_valid |->
      (res_r.feedback_status == ST_IDLE) && (res_r.feedback_rpm == '0))
    else $error("frame fields set without feedback");

  // a word blocked behind a stalled result stays in the input register
  a_item_held : assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !advance |=> item_valid_r && $stable(item_r))
    else $error("input word lost while stalled");

  // a stalled result word is not overwritten
  a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(res_r))
    else $error("result word changed while stalled");

endmodule
